@@ sv/mmws_pkg.sv @@
// Shared types, constants and helpers for the multi-mode word scrambler.
package mmws_pkg;

  localparam int unsigned WORD_W   = 30;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned CHANNELS = 4;
  localparam int unsigned MODES    = 6;
  localparam int unsigned BANK_N   = MODES * CHANNELS;
  localparam int unsigned BANK_AW  = $clog2(BANK_N);

  localparam logic [WORD_W-1:0] SEED_A   = 30'h0000_0000;
  localparam logic [WORD_W-1:0] SEED_ADD = 30'h0000_0007;
  localparam logic [WORD_W-1:0] SEED_B   = 30'h2AAA_AAAA;

  typedef enum logic [MODE_W-1:0] {
    MODE_A_TX   = 3'd0,
    MODE_A_RX   = 3'd1,
    MODE_ADD_TX = 3'd2,
    MODE_ADD_RX = 3'd3,
    MODE_B_TX   = 3'd4,
    MODE_B_RX   = 3'd5
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   channel;
    logic [WORD_W-1:0] data_in;
  } item_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] idx;
    logic [WORD_W-1:0]  data;
  } wr_t;

  function automatic logic [WORD_W-1:0] mode_seed(input int unsigned m);
    logic [WORD_W-1:0] s;
    s = SEED_B;
    if (m < 32'(MODE_ADD_TX)) begin
      s = SEED_A;
    end else if (m < 32'(MODE_B_TX)) begin
      s = SEED_ADD;
    end
    return s;
  endfunction

endpackage

@@ sv/mmws_req_if.sv @@
// Request channel: mode, channel and word to scramble.
interface mmws_req_if;
  logic                       valid;
  logic                       ready;
  logic [mmws_pkg::MODE_W-1:0] mode;
  logic [mmws_pkg::CH_W-1:0]   channel;
  logic [mmws_pkg::WORD_W-1:0] data_in;

  modport source (output valid, output mode, output channel, output data_in, input ready);
  modport sink (input valid, input mode, input channel, input data_in, output ready);
endinterface

@@ sv/mmws_rsp_if.sv @@
// Result channel: scrambled or descrambled word.
interface mmws_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mmws_pkg::WORD_W-1:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

@@ sv/multi_mode_word_scrambler.sv @@
// Top level of the multi-mode word scrambler.
//
// Requests arrive on req_i: a 3-bit mode, a channel number and a 30-bit word.
// The mode selects type A, additive or type B scrambling, TX or RX; each mode
// and channel pair keeps its own 30-bit state. One result word leaves on rsp_o
// for every request; unused modes and channels return 0 and touch no state.
// A request is captured in an input register, transformed by its mode's XOR
// network against the selected state word, and lands in the result register
// while the state word is rewritten at the same edge.
// Throughput: one request per cycle while rsp_o.ready is high, across any mix
// of modes and channels, since the state read and update share one cycle.
// Reset clears both pipeline valids and loads every state word with its seed:
// 0 for type A, 7 for additive, 0x2AAAAAAA for type B.
// When the receiver stalls, the result register holds; the input register
// takes one more request, then req_i.ready drops until the result drains.
module multi_mode_word_scrambler (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmws_req_if.sink    req_i,
  mmws_rsp_if.source  rsp_o
);

  logic                        s1_valid_q;
  mmws_pkg::item_t             s1_item_q;
  logic                        out_valid_q;
  logic [mmws_pkg::WORD_W-1:0] out_data_q;

  logic                         adv;
  logic                         ch_ok;
  logic                         known;
  logic [mmws_pkg::BANK_AW-1:0] idx;
  logic [mmws_pkg::WORD_W-1:0]  st_rd;
  logic [mmws_pkg::WORD_W-1:0]  xf_data;
  logic [mmws_pkg::WORD_W-1:0]  xf_state;
  mmws_pkg::wr_t                wr;

  assign adv         = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || adv;

  assign ch_ok = 32'(s1_item_q.channel) < mmws_pkg::CHANNELS;
  assign idx   = mmws_pkg::BANK_AW'(32'(s1_item_q.mode) * mmws_pkg::CHANNELS
                                    + 32'(s1_item_q.channel));

  mmws_state_bank u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx),
    .rd_data_o (st_rd),
    .wr_i      (wr)
  );

  mmws_xform u_xform (
    .mode_i  (s1_item_q.mode),
    .data_i  (s1_item_q.data_in),
    .state_i (st_rd),
    .data_o  (xf_data),
    .state_o (xf_state),
    .known_o (known)
  );

  always_comb begin
    wr.en   = adv && known && ch_ok;
    wr.idx  = idx;
    wr.data = xf_state;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_item_q.mode    <= req_i.mode;
      s1_item_q.channel <= req_i.channel;
      s1_item_q.data_in <= req_i.data_in;
    end
    if (adv) begin
      out_data_q <= (known && ch_ok) ? xf_data : '0;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.word  = out_data_q;

endmodule

@@ sv/mmws_state_bank.sv @@
// Per mode and channel scrambler state registers with seeded reset.
module mmws_state_bank (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mmws_pkg::BANK_AW-1:0]      rd_idx_i,
  output logic [mmws_pkg::WORD_W-1:0]       rd_data_o,
  input  mmws_pkg::wr_t                     wr_i
);

  logic [mmws_pkg::WORD_W-1:0] st_q [mmws_pkg::BANK_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < mmws_pkg::BANK_N; i++) begin
        st_q[i] <= mmws_pkg::mode_seed(i / mmws_pkg::CHANNELS);
      end
    end else if (wr_i.en) begin
      st_q[wr_i.idx] <= wr_i.data;
    end
  end

  always_comb begin
    rd_data_o = '0;
    if (32'(rd_idx_i) < mmws_pkg::BANK_N) begin
      rd_data_o = st_q[rd_idx_i];
    end
  end

endmodule

@@ sv/mmws_xform.sv @@
// XOR networks of the six scramblers and their next-state values.
module mmws_xform (
  input  logic [mmws_pkg::MODE_W-1:0] mode_i,
  input  logic [mmws_pkg::WORD_W-1:0] data_i,
  input  logic [mmws_pkg::WORD_W-1:0] state_i,
  output logic [mmws_pkg::WORD_W-1:0] data_o,
  output logic [mmws_pkg::WORD_W-1:0] state_o,
  output logic                        known_o
);

  localparam int unsigned W = mmws_pkg::WORD_W;

  logic [W-1:0] f;
  logic [W-1:0] d;
  logic [W-1:0] a_mix;
  logic [W-1:0] a_tx;
  logic [W-1:0] f_rev;
  logic [W-1:0] add_step;
  logic [W-1:0] b_mix;

  assign f = state_i;
  assign d = data_i;

  always_comb begin
    for (int unsigned k = 0; k < W; k++) begin
      f_rev[W-1-k] = f[k];
    end
  end

  assign a_mix    = d ^ f ^ (f >> 2);
  assign a_tx     = a_mix ^ {a_mix[1:0], {(W-2){1'b0}}};
  assign add_step = f ^ {f[W-2:0], 1'b0} ^ {{(W-2){1'b0}}, f[W-1], f[W-1]};
  assign b_mix    = d ^ f ^ {f[0], f[W-1:1]} ^ {f[14:0], f[W-1:15]}
                  ^ {f[15:0], f[W-1:16]};

  always_comb begin
    data_o  = '0;
    state_o = f;
    known_o = 1'b1;
    case (mode_i) inside
      mmws_pkg::MODE_A_TX: begin
        data_o  = a_tx;
        state_o = a_tx;
      end
      mmws_pkg::MODE_A_RX: begin
        data_o  = a_mix ^ {d[1:0], {(W-2){1'b0}}};
        state_o = d;
      end
      mmws_pkg::MODE_ADD_TX, mmws_pkg::MODE_ADD_RX: begin
        data_o  = d ^ f_rev ^ {f[W-1], {(W-1){1'b0}}};
        state_o = add_step;
      end
      mmws_pkg::MODE_B_TX: begin
        data_o  = b_mix;
        state_o = b_mix;
      end
      mmws_pkg::MODE_B_RX: begin
        data_o  = b_mix;
        state_o = d;
      end
      default: begin
        known_o = 1'b0;
      end
    endcase
  end

endmodule
